// ===== rtl/mfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Max-flow DFS augmenting block: shared package
// Field widths, register and request codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mfd_pkg;

	// Fixed widths of the channel fields and the configuration port.
	localparam int NODE_W     = 5;
	localparam int CAP_IN_W   = 16;
	localparam int FLOW_W     = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	// Largest reported flow; larger totals saturate here.
	localparam logic [FLOW_W-1:0] FLOW_MAX = '1;

	// Request types.
	localparam logic REQ_EDGE = 1'b0;
	localparam logic REQ_RUN  = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_NODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SINK_NODE   = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_step;
		logic edge_wr;
		logic run_init;
		logic copy_step;
		logic srch_init;
		logic probe_rd;
		logic probe_chk;
		logic bt_rd;
		logic bt_apply;
		logic walk_init;
		logic par_rd;
		logic res_rd_pv;
		logic bn_upd;
		logic upd_fwd;
		logic upd_bwd;
		logic out_load;
	} mfd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic copy_last;
		logic bad_run;
		logic cur_end;
		logic u_is_s;
		logic probe_hit;
		logic hit_sink;
		logic p_is_s;
	} mfd_sts_t;

endpackage

// ===== rtl/mfd_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying edge writes and run requests.
// ----------------------------------------------------------------------------
interface mfd_req_if import mfd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                req_type;
	logic [NODE_W-1:0]   from_node;
	logic [NODE_W-1:0]   to_node;
	logic [CAP_IN_W-1:0] capacity;

	modport source (output valid, output req_type, output from_node, output to_node,
		output capacity, input ready);
	modport sink (input valid, input req_type, input from_node, input to_node,
		input capacity, output ready);
endinterface

// ===== rtl/mfd_res_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the flow total and the error flag.
// ----------------------------------------------------------------------------
interface mfd_res_if import mfd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FLOW_W-1:0] max_flow;
	logic              flow_error;

	modport source (output valid, output max_flow, output flow_error, input ready);
	modport sink (input valid, input max_flow, input flow_error, output ready);
endinterface

// ===== rtl/mfd_dp.sv =====
// ----------------------------------------------------------------------------
// Max-flow datapath
// Configuration registers, capacity and residual memories, parent memory,
// search registers, bottleneck and flow accumulation, and result registers.
// ----------------------------------------------------------------------------
module mfd_dp import mfd_pkg::*; #(
	parameter int MAX_NODES = 16,
	parameter int CAP_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [NODE_W-1:0]     from_node,
	input  logic [NODE_W-1:0]     to_node,
	input  logic [CAP_IN_W-1:0]   capacity,
	input  mfd_cmd_t              cmd,
	output mfd_sts_t              sts,
	output logic [FLOW_W-1:0]     max_flow,
	output logic                  flow_error
);

	localparam int NW    = $clog2(MAX_NODES);
	localparam int NCW   = NW + 1;
	localparam int AW    = 2 * NW;
	localparam int DEPTH = 1 << AW;
	localparam int RW    = CAP_BITS + 1;
	localparam int SW    = ((FLOW_W > RW) ? FLOW_W : RW) + 1;

	// Configuration registers.
	logic [NODE_W-1:0] node_count_q, source_node_q, sink_node_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q  <= NODE_W'(16);
			source_node_q <= NODE_W'(1);
			sink_node_q   <= NODE_W'(16);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NODE_COUNT:  node_count_q  <= cfg_data;
				CFG_SOURCE_NODE: source_node_q <= cfg_data;
				CFG_SINK_NODE:   sink_node_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective node count, zero-based ends and the run check.
	logic [7:0]     nc8, n8, s8, t8, f8, h8;
	logic [NCW-1:0] n_eff;
	logic [NW-1:0]  s0, t0;
	logic           edge_ok;

	always_comb begin
		nc8     = 8'(node_count_q);
		n_eff   = (nc8 > 8'(MAX_NODES)) ? NCW'(MAX_NODES) : NCW'(nc8);
		n8      = 8'(n_eff);
		s8      = 8'(source_node_q);
		t8      = 8'(sink_node_q);
		f8      = 8'(from_node);
		h8      = 8'(to_node);
		s0      = NW'(source_node_q - NODE_W'(1));
		t0      = NW'(sink_node_q - NODE_W'(1));
		edge_ok = (f8 >= 8'd1) && (f8 <= 8'(MAX_NODES)) &&
			(h8 >= 8'd1) && (h8 <= 8'(MAX_NODES));
	end

	// Sweep counter shared by the clearing pass and the copy.
	logic [AW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.run_init) begin
			cnt_q <= '0;
		end else if (cmd.clr_step || cmd.copy_step) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	// Capacity memory: cleared by the sweep, written by edge beats, read by the copy.
	logic [CAP_BITS-1:0] cap_mem [DEPTH];
	logic [CAP_BITS-1:0] cap_rd_q;
	logic [AW-1:0]       edge_addr;

	assign edge_addr = {NW'(from_node - NODE_W'(1)), NW'(to_node - NODE_W'(1))};

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			cap_mem[cnt_q] <= '0;
		end else if (cmd.edge_wr && edge_ok) begin
			cap_mem[edge_addr] <= CAP_BITS'(capacity);
		end
		if (cmd.copy_step) begin
			cap_rd_q <= cap_mem[cnt_q];
		end
	end

	// Copy write stage, in the cycle after the capacity read.
	logic          copy_wr_s1;
	logic [AW-1:0] copy_addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_wr_s1 <= 1'b0;
		end else begin
			copy_wr_s1 <= cmd.copy_step;
		end
	end

	always_ff @(posedge clk) begin
		copy_addr_s1 <= cnt_q;
	end

	// Search registers.
	logic [NW-1:0]        u_q, v_q, p_q;
	logic [NCW-1:0]       cur_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [RW-1:0]        bn_q;
	logic [FLOW_W-1:0]    flow_q;
	logic                 err_q;
	logic [RW-1:0]        res_rd_q;
	logic [NW-1:0]        par_rd_q;
	logic                 probe_hit;
	logic [SW-1:0]        flow_sum;

	assign probe_hit = (res_rd_q != '0) && !visited_q[NW'(cur_q)];
	assign flow_sum  = SW'(flow_q) + SW'(bn_q);

	// Residual memory: one write and one registered read per cycle.
	logic [RW-1:0] res_mem [DEPTH];
	logic          res_we, res_re;
	logic [AW-1:0] res_wa, res_ra;
	logic [RW-1:0] res_wd;

	always_comb begin
		res_we = 1'b1;
		res_wa = copy_addr_s1;
		res_wd = RW'(cap_rd_q);
		if (copy_wr_s1) begin
			res_wa = copy_addr_s1;
		end else if (cmd.upd_fwd) begin
			res_wa = {p_q, v_q};
			res_wd = res_rd_q - bn_q;
		end else if (cmd.upd_bwd) begin
			res_wa = {v_q, p_q};
			res_wd = res_rd_q + bn_q;
		end else begin
			res_we = 1'b0;
		end
		res_re = 1'b1;
		if (cmd.probe_rd) begin
			res_ra = {u_q, NW'(cur_q)};
		end else if (cmd.res_rd_pv) begin
			res_ra = {par_rd_q, v_q};
		end else begin
			res_ra = {v_q, p_q};
			res_re = cmd.upd_fwd;
		end
	end

	always_ff @(posedge clk) begin
		if (res_we) begin
			res_mem[res_wa] <= res_wd;
		end
		if (res_re) begin
			res_rd_q <= res_mem[res_ra];
		end
	end

	// Parent memory: written when the search steps down, read to back up or walk.
	logic [NW-1:0] par_mem [MAX_NODES];

	always_ff @(posedge clk) begin
		if (cmd.probe_chk && probe_hit) begin
			par_mem[NW'(cur_q)] <= u_q;
		end
		if (cmd.bt_rd) begin
			par_rd_q <= par_mem[u_q];
		end else if (cmd.par_rd) begin
			par_rd_q <= par_mem[v_q];
		end
	end

	// Control registers of the search and the flow total.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			flow_q    <= '0;
			err_q     <= 1'b0;
		end else begin
			if (cmd.run_init) begin
				flow_q <= '0;
				err_q  <= sts.bad_run;
			end else if (cmd.upd_bwd && sts.p_is_s) begin
				flow_q <= (flow_sum > SW'(FLOW_MAX)) ? FLOW_MAX : FLOW_W'(flow_sum);
			end
			if (cmd.srch_init) begin
				visited_q <= MAX_NODES'(1) << s0;
			end else if (cmd.probe_chk && probe_hit) begin
				visited_q[NW'(cur_q)] <= 1'b1;
			end
		end
	end

	// Search and walk payload registers.
	always_ff @(posedge clk) begin
		if (cmd.srch_init) begin
			u_q   <= s0;
			cur_q <= '0;
		end else if (cmd.probe_chk) begin
			if (probe_hit) begin
				u_q   <= NW'(cur_q);
				cur_q <= '0;
			end else begin
				cur_q <= cur_q + NCW'(1);
			end
		end else if (cmd.bt_apply) begin
			u_q   <= par_rd_q;
			cur_q <= NCW'(u_q) + NCW'(1);
		end
		if (cmd.walk_init) begin
			v_q  <= t0;
			bn_q <= '1;
		end else if (cmd.bn_upd) begin
			if (res_rd_q < bn_q) begin
				bn_q <= res_rd_q;
			end
			v_q <= (p_q == s0) ? t0 : p_q;
		end else if (cmd.upd_bwd) begin
			v_q <= p_q;
		end
		if (cmd.res_rd_pv) begin
			p_q <= par_rd_q;
		end
		if (cmd.out_load) begin
			max_flow   <= flow_q;
			flow_error <= err_q;
		end
	end

	// Status toward the controller.
	always_comb begin
		sts.clr_last  = (cnt_q == '1);
		sts.copy_last = (cnt_q == '1);
		sts.bad_run   = (s8 < 8'd1) || (s8 > n8) || (t8 < 8'd1) || (t8 > n8) ||
			(s8 == t8);
		sts.cur_end   = (cur_q >= n_eff);
		sts.u_is_s    = (u_q == s0);
		sts.probe_hit = probe_hit;
		sts.hit_sink  = (NW'(cur_q) == t0);
		sts.p_is_s    = (p_q == s0);
	end

endmodule

// ===== rtl/mfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Max-flow controller
// Sequences the clearing pass, edge writes, residual copy, depth-first
// search, bottleneck walk, residual update and result hand-off.
// ----------------------------------------------------------------------------
module mfd_ctrl import mfd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_req_type,
	input  logic     out_ready,
	input  mfd_sts_t sts,
	output logic     in_ready,
	output logic     out_valid,
	output mfd_cmd_t cmd
);

	typedef enum logic [15:0] {
		ST_CLR   = 16'h0001,
		ST_IDLE  = 16'h0002,
		ST_COPY  = 16'h0004,
		ST_SINIT = 16'h0008,
		ST_PRD   = 16'h0010,
		ST_PCHK  = 16'h0020,
		ST_BTAP  = 16'h0040,
		ST_WINIT = 16'h0080,
		ST_BRD   = 16'h0100,
		ST_BRES  = 16'h0200,
		ST_BMIN  = 16'h0400,
		ST_URD   = 16'h0800,
		ST_URES  = 16'h1000,
		ST_UFWD  = 16'h2000,
		ST_UBWD  = 16'h4000,
		ST_DONE  = 16'h8000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   in_beat;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_beat   = in_ready && in_valid;
	assign out_valid = out_valid_q;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_beat) begin
					if (in_req_type == REQ_EDGE) begin
						cmd.edge_wr = 1'b1;
					end else begin
						cmd.run_init = 1'b1;
						state_d = sts.bad_run ? ST_DONE : ST_COPY;
					end
				end
			end
			ST_COPY: begin
				cmd.copy_step = 1'b1;
				if (sts.copy_last) begin
					state_d = ST_SINIT;
				end
			end
			ST_SINIT: begin
				cmd.srch_init = 1'b1;
				state_d = ST_PRD;
			end
			ST_PRD: begin
				if (!sts.cur_end) begin
					cmd.probe_rd = 1'b1;
					state_d = ST_PCHK;
				end else if (sts.u_is_s) begin
					state_d = ST_DONE;
				end else begin
					cmd.bt_rd = 1'b1;
					state_d = ST_BTAP;
				end
			end
			ST_PCHK: begin
				cmd.probe_chk = 1'b1;
				state_d = (sts.probe_hit && sts.hit_sink) ? ST_WINIT : ST_PRD;
			end
			ST_BTAP: begin
				cmd.bt_apply = 1'b1;
				state_d = ST_PRD;
			end
			ST_WINIT: begin
				cmd.walk_init = 1'b1;
				state_d = ST_BRD;
			end
			ST_BRD: begin
				cmd.par_rd = 1'b1;
				state_d = ST_BRES;
			end
			ST_BRES: begin
				cmd.res_rd_pv = 1'b1;
				state_d = ST_BMIN;
			end
			ST_BMIN: begin
				cmd.bn_upd = 1'b1;
				state_d = sts.p_is_s ? ST_URD : ST_BRD;
			end
			ST_URD: begin
				cmd.par_rd = 1'b1;
				state_d = ST_URES;
			end
			ST_URES: begin
				cmd.res_rd_pv = 1'b1;
				state_d = ST_UFWD;
			end
			ST_UFWD: begin
				cmd.upd_fwd = 1'b1;
				state_d = ST_UBWD;
			end
			ST_UBWD: begin
				cmd.upd_bwd = 1'b1;
				state_d = sts.p_is_s ? ST_SINIT : ST_URD;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLR;
			end
		endcase
	end

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/max_flow_dfs_augment.sv =====
// ----------------------------------------------------------------------------
// Max-flow by depth-first augmenting paths
//
//   Channel | Direction | Beat contents
//   --------+-----------+----------------------------------------------
//   req     | in        | req_type, from_node, to_node, capacity
//   res     | out       | max_flow, flow_error (one beat per run request)
//   cfg     | in        | cfg_we, cfg_index, cfg_data (node count, ends)
//
// After reset a clearing pass zeroes all 2^(2*clog2(MAX_NODES)) capacity
// memory entries (256 at the default); req is not ready meanwhile.
// A run copies the capacity memory in a sweep like the clearing pass, then
// searches: each neighbor probe is a read and a check, each back-up step a
// parent read and an apply, each search and each walk has a start step,
// and each path node has a bottleneck step and an update step, all through
// the residual memory's one read port and one write port.
// A finished result waits in an output register; edge beats keep flowing.
// ----------------------------------------------------------------------------
module max_flow_dfs_augment import mfd_pkg::*; #(
	parameter int MAX_NODES = 16,
	parameter int CAP_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mfd_req_if.sink               req,
	mfd_res_if.source             res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	mfd_cmd_t cmd;
	mfd_sts_t sts;

	// Controller.
	mfd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_req_type (req.req_type),
		.out_ready   (res.ready),
		.sts         (sts),
		.in_ready    (req.ready),
		.out_valid   (res.valid),
		.cmd         (cmd)
	);

	// Datapath.
	mfd_dp #(
		.MAX_NODES (MAX_NODES),
		.CAP_BITS  (CAP_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.from_node  (req.from_node),
		.to_node    (req.to_node),
		.capacity   (req.capacity),
		.cmd        (cmd),
		.sts        (sts),
		.max_flow   (res.max_flow),
		.flow_error (res.flow_error)
	);

endmodule

// ===== tb/sv/max_flow_checker.sv =====
// ----------------------------------------------------------------------------
// Max-flow checker
// Watches the request, result and configuration ports. It keeps its own copy
// of the capacity matrix and the registers, works out the flow of every run
// beat by depth-first augmenting paths, and compares each result beat with
// the oldest predicted flow.
// ----------------------------------------------------------------------------
module max_flow_checker import mfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	mfd_req_if                    req,
	mfd_res_if                    res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    flows_pending
);

	localparam int NODES = 16;

	typedef struct packed {
		logic [FLOW_W-1:0] max_flow;
		logic              flow_error;
	} flow_result_t;

	logic [CAP_IN_W-1:0]   cap_matrix [1:NODES][1:NODES];
	logic [CFG_DATA_W-1:0] node_count;
	logic [CFG_DATA_W-1:0] source_node;
	logic [CFG_DATA_W-1:0] sink_node;
	flow_result_t          expected_flows [$];

	// Ford-Fulkerson with one visited set per search, neighbors in rising order.
	function automatic flow_result_t predict_flow();
		int           resid [1:NODES][1:NODES];
		int           parent [1:NODES];
		int           cursor [1:NODES];
		logic [NODES:0] seen;
		int           n, s, t, u, v, i, bneck, guard;
		longint       total;
		bit           moved, found;
		flow_result_t r;
		n = (int'(node_count) > NODES) ? NODES : int'(node_count);
		s = int'(source_node);
		t = int'(sink_node);
		r.max_flow   = '0;
		r.flow_error = 1'b1;
		if (s < 1 || s > n || t < 1 || t > n || s == t)
			return r;
		for (u = 1; u <= NODES; u++)
			for (v = 1; v <= NODES; v++)
				resid[u][v] = int'(cap_matrix[u][v]);
		total = 0;
		do begin
			// Search for one augmenting path.
			u = s;
			seen = '0;
			seen[s] = 1'b1;
			cursor[s] = 1;
			found = 0;
			forever begin
				if (u == t) begin
					found = 1;
					break;
				end
				moved = 0;
				while (cursor[u] <= n) begin
					i = cursor[u];
					cursor[u]++;
					if (resid[u][i] > 0 && !seen[i]) begin
						parent[i] = u;
						seen[i] = 1'b1;
						cursor[i] = 1;
						u = i;
						moved = 1;
						break;
					end
				end
				if (!moved) begin
					if (u == s)
						break;
					u = parent[u];
				end
			end
			// Push the bottleneck along the path.
			if (found) begin
				bneck = 32'h7fff_ffff;
				for (v = t, guard = 0; v != s && guard < n; v = parent[v], guard++)
					if (resid[parent[v]][v] < bneck)
						bneck = resid[parent[v]][v];
				for (v = t, guard = 0; v != s && guard < n; v = parent[v], guard++) begin
					resid[parent[v]][v] -= bneck;
					resid[v][parent[v]] += bneck;
				end
				total += bneck;
			end
		end while (found);
		r.max_flow   = (total > FLOW_MAX) ? FLOW_MAX : total[FLOW_W-1:0];
		r.flow_error = 1'b0;
		return r;
	endfunction

	// Track registers, edge beats and run beats; check every result beat.
	always @(posedge clk or negedge arst_n) begin
		flow_result_t want;
		if (!arst_n) begin
			for (int a = 1; a <= NODES; a++)
				for (int b = 1; b <= NODES; b++)
					cap_matrix[a][b] = '0;
			node_count    = 5'd16;
			source_node   = 5'd1;
			sink_node     = 5'd16;
			expected_flows.delete();
			fail_count    = 0;
			flows_pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_NODE_COUNT:  node_count = cfg_data;
					CFG_SOURCE_NODE: source_node = cfg_data;
					CFG_SINK_NODE:   sink_node = cfg_data;
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				if (expected_flows.size() == 0) begin
					$error("unexpected result beat: max_flow %0d flow_error %0d",
						res.max_flow, res.flow_error);
					fail_count++;
				end else begin
					want = expected_flows.pop_front();
					if (res.max_flow !== want.max_flow) begin
						$error("max_flow: expected %0d, actual %0d", want.max_flow, res.max_flow);
						fail_count++;
					end
					if (res.flow_error !== want.flow_error) begin
						$error("flow_error: expected %0d, actual %0d",
							want.flow_error, res.flow_error);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.req_type == REQ_EDGE) begin
					if (req.from_node >= 1 && req.from_node <= NODES &&
						req.to_node >= 1 && req.to_node <= NODES)
						cap_matrix[req.from_node][req.to_node] = req.capacity;
				end else begin
					expected_flows.push_back(predict_flow());
				end
			end
			flows_pending = expected_flows.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Max-flow block testbench
// Loads capacity matrices edge by edge, runs the flow search under several
// register settings, and lets the checker compare every result. A directed
// part covers field extremes and error runs; a random part builds graphs of
// mostly small size with random capacities, with both sides idling at random in its first two thirds.
// ----------------------------------------------------------------------------
module tb;
	import mfd_pkg::*;

	localparam int  ITEM_TARGET = 1800;
	localparam int  CYCLE_LIMIT = 20_000_000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    flows_pending;
	int                    src_idle_pct;
	int                    sink_idle_pct;
	int                    cycle_count;
	int                    items_done;

	mfd_req_if req_ch ();
	mfd_res_if res_ch ();

	max_flow_dfs_augment dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	max_flow_checker flow_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.res           (res_ch),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.flows_pending (flows_pending)
	);

	// Clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Cycle limit.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[max_flow_dfs_augment] ERROR");
			$finish;
		end
	end

	// Result side stalls at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_ch.ready <= 1'b0;
		else
			res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// Send one request beat, idling first at random.
	task automatic send_beat(logic kind, logic [NODE_W-1:0] from_n, logic [NODE_W-1:0] to_n,
		logic [CAP_IN_W-1:0] cap);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= kind;
		req_ch.from_node <= from_n;
		req_ch.to_node   <= to_n;
		req_ch.capacity  <= cap;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Hold off until every predicted flow has arrived and the block has settled.
	task automatic wait_all_flows();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (flows_pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all three registers on consecutive cycles.
	task automatic write_config(logic [CFG_DATA_W-1:0] n, logic [CFG_DATA_W-1:0] s,
		logic [CFG_DATA_W-1:0] t);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_NODE_COUNT;
		cfg_data  <= n;
		@(posedge clk);
		cfg_index <= CFG_SOURCE_NODE;
		cfg_data  <= s;
		@(posedge clk);
		cfg_index <= CFG_SINK_NODE;
		cfg_data  <= t;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Stimulus and verdict.
	initial begin
		int n, nn, s, t, edges, pick, f, g;
		logic [CAP_IN_W-1:0] cap;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = CFG_NODE_COUNT;
		cfg_data         = '0;
		req_ch.valid     = 1'b0;
		req_ch.req_type  = REQ_EDGE;
		req_ch.from_node = '0;
		req_ch.to_node   = '0;
		req_ch.capacity  = '0;
		src_idle_pct     = 24;
		sink_idle_pct    = 67;
		items_done       = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extreme capacities, self loop, ignored edges, bad runs.
		send_beat(REQ_EDGE, 5'd1, 5'd2, 16'hFFFF);
		send_beat(REQ_EDGE, 5'd2, 5'd16, 16'hFFFF);
		send_beat(REQ_EDGE, 5'd1, 5'd16, 16'hFFFF);
		send_beat(REQ_EDGE, 5'd1, 5'd1, 16'd500);
		send_beat(REQ_EDGE, 5'd16, 5'd1, 16'd0);
		send_beat(REQ_EDGE, 5'd0, 5'd5, 16'd77);
		send_beat(REQ_EDGE, 5'd17, 5'd3, 16'd88);
		send_beat(REQ_EDGE, 5'd3, 5'd31, 16'd99);
		send_beat(REQ_EDGE, 5'd31, 5'd0, 16'hFFFF);
		send_beat(REQ_RUN, 5'd0, 5'd0, 16'd0);
		wait_all_flows();
		write_config(5'd31, 5'd1, 5'd16);
		send_beat(REQ_RUN, 5'd31, 5'd31, 16'hFFFF);
		wait_all_flows();
		write_config(5'd16, 5'd4, 5'd4);
		send_beat(REQ_RUN, 5'd0, 5'd0, 16'd0);
		wait_all_flows();
		write_config(5'd0, 5'd1, 5'd2);
		send_beat(REQ_RUN, 5'd0, 5'd0, 16'd0);
		wait_all_flows();
		write_config(5'd2, 5'd1, 5'd16);
		send_beat(REQ_RUN, 5'd0, 5'd0, 16'd0);
		wait_all_flows();
		write_config(5'd2, 5'd1, 5'd2);
		send_beat(REQ_EDGE, 5'd1, 5'd2, 16'd7);
		send_beat(REQ_RUN, 5'd0, 5'd0, 16'd0);
		wait_all_flows();
		write_config(5'd16, 5'd0, 5'd2);
		send_beat(REQ_RUN, 5'd0, 5'd0, 16'd0);
		wait_all_flows();
		write_config(5'd16, 5'd31, 5'd2);
		send_beat(REQ_RUN, 5'd0, 5'd0, 16'd0);

		// Random part: one graph per pass of the loop, then a run.
		while (items_done < ITEM_TARGET) begin
			case (items_done * 3 / ITEM_TARGET)
				0: begin src_idle_pct = 24; sink_idle_pct = 67; end
				1: begin src_idle_pct = 67; sink_idle_pct = 24; end
				default: begin src_idle_pct = 0; sink_idle_pct = 0; end
			endcase
			wait_all_flows();
			pick = $urandom_range(9);
			if (pick == 0)
				n = 16;
			else if (pick == 1)
				n = $urandom_range(17, 31);
			else
				n = $urandom_range(2, 8);
			nn = (n > 16) ? 16 : n;
			s = $urandom_range(1, nn);
			t = $urandom_range(1, nn);
			if (t == s)
				t = (s == nn) ? 1 : s + 1;
			if ($urandom_range(9) == 0) begin
				s = $urandom_range(0, 31);
				t = $urandom_range(0, 31);
			end
			write_config(CFG_DATA_W'(n), CFG_DATA_W'(s), CFG_DATA_W'(t));
			edges = $urandom_range(5, 40);
			repeat (edges) begin
				pick = $urandom_range(3);
				cap = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom_range(1, 15))
					: 16'($urandom);
				if ($urandom_range(9) == 0) begin
					f = $urandom_range(0, 31);
					g = $urandom_range(0, 31);
				end else begin
					f = $urandom_range(1, nn);
					g = $urandom_range(1, nn);
				end
				send_beat(REQ_EDGE, NODE_W'(f), NODE_W'(g), cap);
				items_done++;
			end
			send_beat(REQ_RUN, NODE_W'($urandom), NODE_W'($urandom), CAP_IN_W'($urandom));
			items_done++;
		end

		wait_all_flows();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && flows_pending == 0)
			$display("[max_flow_dfs_augment] OK");
		else
			$display("[max_flow_dfs_augment] ERROR");
		$finish;
	end

endmodule
